@@ rtl/dq_pkg.sv @@
package dq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_LIST       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_SHR   = 3'd1,
    CELL_SHL   = 3'd2,
    CELL_ROT   = 3'd3,
    CELL_WRITE = 3'd4
  } cell_cmd_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] value;
  } dq_in_t;

  typedef struct packed {
    logic signed [31:0] data;
    status_e            status;
    logic [4:0]         occupancy;
    logic               last;
  } dq_out_t;

  typedef struct packed {
    cell_cmd_e          cmd;
    logic signed [31:0] value;
    logic signed [31:0] wrap;
  } dq_ctrl_t;

endpackage

@@ rtl/dq_cell.sv @@
module dq_cell (
  input  logic                      clk_i,
  input  dq_pkg::dq_ctrl_t          ctrl_i,
  input  logic                      is_tail_i,
  input  logic                      is_free_i,
  input  logic signed [31:0]        left_i,
  input  logic signed [31:0]        right_i,
  output logic signed [31:0]        data_o
);
  import dq_pkg::*;

  logic signed [31:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.cmd)
      CELL_HOLD:  data_d = data_q;
      CELL_SHR:   data_d = left_i;
      CELL_SHL:   data_d = right_i;
      CELL_ROT:   data_d = is_tail_i ? ctrl_i.wrap : right_i;
      CELL_WRITE: data_d = is_free_i ? ctrl_i.value : data_q;
      default:    data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ rtl/double_ended_queue_unit.sv @@
// Bounded double-ended queue of signed 32-bit values, held front to rear in a row
// of DEPTH cells, with the front entry always in the first cell.
// Input channel: in_valid_i, in_ready_o and in_data_i (op and value). Output
// channel: out_valid_o, out_ready_i and out_data_o (data, status, occupancy, last).
// A push or pop transaction yields one result, visible in the cycle after acceptance.
// A push at the front shifts the row by one cell, a pop at the front shifts it
// back; a rear push writes only the cell past the tail, a rear pop no cell.
// A list transaction of N held entries yields one result per entry, front to rear,
// one a cycle while the receiver takes them; each goes through the list state into
// the output register. The row rotates by one cell per result, which leaves the
// order intact, and the block accepts nothing more until the list state has ended.
// A new transaction is accepted once the previous one has finished and the output
// register is empty or being emptied, so the block sustains one push or pop per
// cycle while results are taken. When the receiver stalls, the result
// waits in the output register and no input is accepted. Operation codes 5 to 7 are accepted and yield nothing.
// Reset empties the queue and the output register; cell contents are not cleared.
module double_ended_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dq_pkg::dq_in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dq_pkg::dq_out_t  out_data_o
);
  import dq_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_e;

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      remain_q, remain_d;
  logic                 out_valid_q, out_valid_d;
  dq_out_t              out_q, out_d;
  dq_ctrl_t             ctrl;
  logic signed [31:0]   cell_data [DEPTH];
  logic [DEPTH-1:0]     is_tail;
  logic [DEPTH-1:0]     is_free;
  logic signed [31:0]   tail_data;
  logic                 slot_free;
  logic                 in_fire;

  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      is_tail[i] = (count_q == CntW'(i + 1));
      is_free[i] = (count_q == CntW'(i));
      tail_data  = tail_data | (is_tail[i] ? cell_data[i] : 32'sd0);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] left, right;
    if (g == 0) begin : g_first
      assign left = in_data_i.value;
    end else begin : g_mid
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_inner
      assign right = cell_data[g+1];
    end
    dq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .is_tail_i (is_tail[g]),
      .is_free_i (is_free[g]),
      .left_i    (left),
      .right_i   (right),
      .data_o    (cell_data[g])
    );
  end

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    remain_d    = remain_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ctrl.cmd    = CELL_HOLD;
    ctrl.value  = in_data_i.value;
    ctrl.wrap   = cell_data[0];
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_d.data   = '0;
          out_d.status = ST_OK;
          out_d.last   = 1'b1;
          priority if (in_data_i.op == OP_PUSH_FRONT || in_data_i.op == OP_PUSH_REAR) begin
            out_valid_d = 1'b1;
            if (count_q == CntW'(DEPTH)) begin
              out_d.status = ST_FULL;
            end else begin
              ctrl.cmd = (in_data_i.op == OP_PUSH_FRONT) ? CELL_SHR : CELL_WRITE;
              count_d  = count_q + CntW'(1);
            end
          end else if (in_data_i.op == OP_POP_FRONT || in_data_i.op == OP_POP_REAR) begin
            out_valid_d = 1'b1;
            if (count_q == '0) begin
              out_d.status = ST_EMPTY;
            end else begin
              if (in_data_i.op == OP_POP_FRONT) begin
                ctrl.cmd   = CELL_SHL;
                out_d.data = cell_data[0];
              end else begin
                out_d.data = tail_data;
              end
              count_d = count_q - CntW'(1);
            end
          end else if (in_data_i.op == OP_LIST) begin
            if (count_q == '0) begin
              out_valid_d  = 1'b1;
              out_d.status = ST_EMPTY;
            end else begin
              state_d  = S_LIST;
              remain_d = count_q;
            end
          end else begin
            out_d = out_q;
          end
          out_d.occupancy = 5'(count_d);
        end
      end
      S_LIST: begin
        if (slot_free) begin
          out_valid_d     = 1'b1;
          out_d.data      = cell_data[0];
          out_d.status    = ST_OK;
          out_d.occupancy = 5'(count_q);
          out_d.last      = (remain_q == CntW'(1));
          ctrl.cmd        = CELL_ROT;
          remain_d        = remain_q - CntW'(1);
          if (remain_q == CntW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("Entry count exceeds the queue depth.");

  a_list_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LIST |-> count_q != '0 && remain_q != '0 && remain_q <= count_q)
    else $error("Listing with an inconsistent entry count.");

  a_list_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.op == OP_LIST && count_q != '0 |=> state_q == S_LIST)
    else $error("List transaction did not start a walk.");

  a_error_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.data == 32'sd0 && out_data_o.last)
    else $error("Error result carries data or is not final.");
`endif

endmodule
